[rtl/wsd_pkg.sv]
package wsd_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 20;
    localparam int COUNT_OUT_W  = 5;
    localparam int MIN_SAMPLES  = 2;

    localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int SQ_W    = 2 * SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int PROD_W  = SQ_W + CNT_W;
    localparam int ROOT_W  = (PROD_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int TRIAL_W = REM_W + 2;
    localparam int STEP_W  = $clog2(ROOT_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + COUNT_OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] s1;
        logic [SQ_W-1:0]  s2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SQUARE,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUB,
        BK_SQRT,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

[rtl/wsd_front.sv]
module wsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wsd_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_push,
    output wsd_pkg::t_job                 o_job,
    input  wsd_pkg::t_queue_status        i_qstat
);
    import wsd_pkg::*;

    t_front_state r_state, n_state;

    logic [SAMPLE_W-1:0]   r_mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]   r_x;
    logic [SAMPLE_W-1:0]   r_old;
    logic [2*SAMPLE_W-1:0] r_x_sq;
    logic [2*SAMPLE_W-1:0] r_old_sq;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic             r_full, n_full;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SQ_W-1:0]  r_sq_sum, n_sq_sum;

    logic accept;
    logic wrap;
    logic [SAMPLE_W-1:0]   old_term;
    logic [2*SAMPLE_W-1:0] old_sq_term;

    assign o_ready = (r_state == FR_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        wrap        = (r_wp == PTR_W'(WINDOW_DEPTH - 1));
        n_wp        = wrap ? '0 : r_wp + 1'b1;
        n_full      = r_full | wrap;
        old_term    = r_full ? r_old : '0;
        old_sq_term = r_full ? r_old_sq : '0;
        n_sum       = r_sum - SUM_W'(old_term) + SUM_W'(r_x);
        n_sq_sum    = r_sq_sum - SQ_W'(old_sq_term) + SQ_W'(r_x_sq);
        o_job.n     = n_full ? CNT_W'(WINDOW_DEPTH) : CNT_W'(n_wp);
        o_job.s1    = n_sum;
        o_job.s2    = n_sq_sum;
        o_push      = (r_state == FR_PUSH) && !i_qstat.full;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (accept) n_state = FR_SQUARE;
            end
            FR_SQUARE: begin
                n_state = FR_PUSH;
            end
            FR_PUSH: begin
                if (!i_qstat.full) n_state = FR_IDLE;
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring store, old entry read back before it is overwritten
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old        <= r_mem[r_wp];
            r_mem[r_wp]  <= i_sample;
            r_x          <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FR_SQUARE) begin
            r_x_sq   <= r_x * r_x;
            r_old_sq <= r_old * r_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_sq_sum <= '0;
        end else if (o_push) begin
            r_wp     <= n_wp;
            r_full   <= n_full;
            r_sum    <= n_sum;
            r_sq_sum <= n_sq_sum;
        end
    end

endmodule

[rtl/wsd_queue.sv]
module wsd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  wsd_pkg::t_job          i_job,
    input  logic                   i_pop,
    output wsd_pkg::t_job          o_job,
    output wsd_pkg::t_queue_status o_stat
);
    import wsd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/wsd_back.sv]
module wsd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wsd_pkg::t_queue_status           i_qstat,
    input  wsd_pkg::t_job                    i_job,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wsd_pkg::SAMPLE_W-1:0]     o_std_dev,
    output logic                             o_valid_res,
    output logic [wsd_pkg::COUNT_OUT_W-1:0]  o_sample_count
);
    import wsd_pkg::*;

    t_back_state r_state, n_state;

    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_s1;
    logic [SQ_W-1:0]    r_s2;
    logic [PROD_W-1:0]  r_a;
    logic [2*SUM_W-1:0] r_b;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W-1:0]  r_root;
    logic [REM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_drem;
    logic [STEP_W-1:0]  r_step;

    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_std_dev;
    logic                   r_valid_res;
    logic [COUNT_OUT_W-1:0] r_count;

    logic               last_step;
    logic               load;
    logic [TRIAL_W-1:0] rem_sh;
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] rem_diff;
    logic [CNT_W:0]     dr_sh;
    logic [CNT_W:0]     dr_diff;
    logic [PROD_W-1:0]  b_ext;

    always_comb begin
        last_step = (r_step == STEP_W'(ROOT_W - 1));
        load      = (r_state == BK_DONE) && (!r_out_valid || i_ready);
        o_pop     = (r_state == BK_IDLE) && !i_qstat.empty;
        rem_sh    = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial     = TRIAL_W'({r_root, 2'b01});
        rem_diff  = rem_sh - trial;
        dr_sh     = {r_drem, r_root[ROOT_W-1]};
        dr_diff   = dr_sh - {1'b0, r_n};
        b_ext     = PROD_W'(r_b);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) n_state = BK_MUL;
            end
            BK_MUL: begin
                n_state = BK_SUB;
            end
            BK_SUB: begin
                n_state = BK_SQRT;
            end
            BK_SQRT: begin
                if (last_step) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (last_step) n_state = BK_DONE;
            end
            BK_DONE: begin
                if (load) n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    r_n  <= i_job.n;
                    r_s1 <= i_job.s1;
                    r_s2 <= i_job.s2;
                end
            end
            BK_MUL: begin
                r_a <= r_n * r_s2;
                r_b <= r_s1 * r_s1;
            end
            BK_SUB: begin
                r_rad  <= (r_a > b_ext) ? RAD_W'(r_a - b_ext) : '0;
                r_root <= '0;
                r_rem  <= '0;
                r_step <= '0;
            end
            // square root, one result bit per cycle
            BK_SQRT: begin
                r_rad <= r_rad << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= REM_W'(rem_diff);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(rem_sh);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (last_step) begin
                    r_step <= '0;
                    r_drem <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            // restoring divide of the root by the count, quotient shifts into r_root
            BK_DIV: begin
                if (dr_sh >= {1'b0, r_n}) begin
                    r_drem <= dr_diff[CNT_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_drem <= dr_sh[CNT_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_std_dev   <= r_root[SAMPLE_W-1:0];
            r_valid_res <= (r_n >= CNT_W'(MIN_SAMPLES));
            r_count     <= COUNT_OUT_W'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_std_dev      = r_std_dev;
    assign o_valid_res    = r_valid_res;
    assign o_sample_count = r_count;

endmodule

[rtl/windowed_standard_deviation.sv]
// Sliding-window standard deviation of light samples (unsigned, 4 fraction bits).
// Each sample enters a ring of the last WINDOW_DEPTH samples; every transaction in
// returns one transaction out with floor(isqrt(n*S2 - S1^2) / n), a flag on tuser
// that is set once two or more samples are held, and the sample count. The front
// end takes a new sample only once its previous one is pushed into the queue, and
// updates the ring and running sums; a two-entry queue feeds the back end, which
// handles one item at a time with a square root and a restoring divide that each
// give one bit per cycle. The result stays in an output register until it is taken.
module windowed_standard_deviation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // sample
    input  logic [wsd_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // std_dev, sample_count
    output logic [wsd_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // valid_res
    output logic                              o_m_axis_tuser
);
    import wsd_pkg::*;

    logic                   w_push;
    logic                   w_pop;
    t_job                   w_job_in;
    t_job                   w_job_out;
    t_queue_status          w_qstat;
    logic [SAMPLE_W-1:0]    w_std_dev;
    logic [COUNT_OUT_W-1:0] w_count;

    wsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample (i_s_axis_tdata[SAMPLE_W-1:0]),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .i_qstat  (w_qstat)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_qstat)
    );

    wsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (w_qstat),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_std_dev      (w_std_dev),
        .o_valid_res    (o_m_axis_tuser),
        .o_sample_count (w_count)
    );

    assign o_m_axis_tdata = M_TDATA_W'({w_count, w_std_dev});

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("push into full queue");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

    a_flag_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == (w_count >= COUNT_OUT_W'(MIN_SAMPLES))))
        else $error("valid flag disagrees with sample count");

    a_zero_dev_when_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (w_std_dev == '0))
        else $error("nonzero deviation with fewer than two samples");

endmodule
